### src/saih_pkg.sv
`timescale 1ns / 1ps

package saih_pkg;

    localparam logic [63:0] FNV_OFFSET_BASIS = 64'hCBF29CE484222325;
    localparam int          DOMAIN_LEN       = 14;

    localparam logic [7:0] DOMAIN_BYTES [DOMAIN_LEN] = '{
        8'h45, 8'h38, 8'h37, 8'h2D, 8'h53, 8'h30, 8'h2D,
        8'h41, 8'h44, 8'h44, 8'h52, 8'h2D, 8'h76, 8'h31
    };

    localparam logic [7:0]  BYTE_ZERO   = 8'h00;
    localparam logic [7:0]  BYTE_ONES   = 8'hFF;
    localparam logic [1:0]  TYPE_BITS   = 2'b11;
    localparam int          ADDR_W      = 48;
    localparam int          RANDOM_W    = 46;

    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_ID_DEGEN    = 2'd1,
        STATUS_RANDOM_DEGEN = 2'd2
    } derive_status_t;

    typedef struct packed {
        logic [RANDOM_W-1:0] hash_low;
        logic                id_degen;
    } saih_raw_t;

    // xor then multiply by 0x100000001B3 as shift-add, mod 2^64
    function automatic logic [63:0] fnv_absorb(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

    function automatic logic [63:0] domain_seed();
        logic [63:0] h;
        h = FNV_OFFSET_BASIS;
        for (int i = 0; i < DOMAIN_LEN; i++)
        begin
            h = fnv_absorb(h, DOMAIN_BYTES[i]);
        end
        return h;
    endfunction

    localparam logic [63:0] HASH_SEED = domain_seed();

endpackage

### src/saih_hash.sv
`timescale 1ns / 1ps

module saih_hash
    import saih_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       id_valid,
    input  logic [7:0] id_byte,
    input  logic       id_last,
    output logic       id_stall,
    output saih_raw_t  raw,
    output logic       raw_valid,
    input  logic       raw_ready
);

    logic [63:0] hash_reg;
    logic [63:0] hash_next;
    logic        all_zero_reg;
    logic        all_zero_next;
    logic        all_ones_reg;
    logic        all_ones_next;
    saih_raw_t   raw_reg;
    saih_raw_t   raw_next;
    logic        raw_valid_reg;
    logic        raw_valid_next;
    logic        accept;
    logic [63:0] absorbed;
    logic        zero_upd;
    logic        ones_upd;

    assign id_stall = raw_valid_reg && !raw_ready;
    assign accept   = id_valid && !id_stall;
    assign absorbed = fnv_absorb(hash_reg, id_byte);
    assign zero_upd = all_zero_reg && (id_byte == BYTE_ZERO);
    assign ones_upd = all_ones_reg && (id_byte == BYTE_ONES);

    always_comb
    begin
        hash_next      = hash_reg;
        all_zero_next  = all_zero_reg;
        all_ones_next  = all_ones_reg;
        raw_next       = raw_reg;
        raw_valid_next = raw_valid_reg && !raw_ready;
        if (accept)
        begin
            if (id_last)
            begin
                hash_next          = HASH_SEED;
                all_zero_next      = 1'b1;
                all_ones_next      = 1'b1;
                raw_next.hash_low  = absorbed[RANDOM_W-1:0];
                raw_next.id_degen  = zero_upd || ones_upd;
                raw_valid_next     = 1'b1;
            end
            else
            begin
                hash_next     = absorbed;
                all_zero_next = zero_upd;
                all_ones_next = ones_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg      <= HASH_SEED;
            all_zero_reg  <= 1'b1;
            all_ones_reg  <= 1'b1;
            raw_valid_reg <= 1'b0;
        end
        else
        begin
            hash_reg      <= hash_next;
            all_zero_reg  <= all_zero_next;
            all_ones_reg  <= all_ones_next;
            raw_valid_reg <= raw_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        raw_reg <= raw_next;
    end

    assign raw       = raw_reg;
    assign raw_valid = raw_valid_reg;

endmodule

### src/saih_format.sv
`timescale 1ns / 1ps

module saih_format
    import saih_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  saih_raw_t         raw,
    input  logic              raw_valid,
    output logic              raw_ready,
    output logic [ADDR_W-1:0] derived_address,
    output logic [1:0]        derive_status,
    output logic              addr_valid,
    input  logic              addr_stall
);

    logic [ADDR_W-1:0]   address_reg;
    logic [ADDR_W-1:0]   address_next;
    derive_status_t      status_reg;
    derive_status_t      status_next;
    logic                valid_reg;
    logic                valid_next;
    logic [RANDOM_W-1:0] rnd;
    logic                take;

    assign raw_ready = !valid_reg || !addr_stall;
    assign take      = raw_valid && raw_ready;
    assign rnd       = raw.hash_low[RANDOM_W-1:0];

    always_comb
    begin
        address_next = address_reg;
        status_next  = status_reg;
        valid_next   = valid_reg && addr_stall;
        if (take)
        begin
            valid_next = 1'b1;
            if (raw.id_degen)
            begin
                status_next  = STATUS_ID_DEGEN;
                address_next = '0;
            end
            else if ((rnd == '0) || (rnd == '1))
            begin
                status_next  = STATUS_RANDOM_DEGEN;
                address_next = '0;
            end
            else
            begin
                status_next  = STATUS_OK;
                address_next = {TYPE_BITS, rnd};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        address_reg <= address_next;
        status_reg  <= status_next;
    end

    assign derived_address = address_reg;
    assign derive_status   = status_reg;
    assign addr_valid      = valid_reg;

endmodule

### src/static_address_from_id_hash.sv
`timescale 1ns / 1ps

// Channel   Handshake             Payload
// id        id_valid / id_stall   id_byte[7:0], id_last
// addr      addr_valid / addr_stall  derived_address[47:0], derive_status[1:0]
//
// One id byte per cycle while id_stall is low; the hash state register closes the feedback loop.
// After the transfer of the byte marked id_last, the result passes the middle and then the output register.
// Reset loads the hash seed and clears both valid stages.
// addr_stall backs up through the output and middle registers to id_stall.

module static_address_from_id_hash
    import saih_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              id_valid,
    output logic              id_stall,
    input  logic [7:0]        id_byte,
    input  logic              id_last,
    output logic              addr_valid,
    input  logic              addr_stall,
    output logic [ADDR_W-1:0] derived_address,
    output logic [1:0]        derive_status
);

    saih_raw_t raw;
    logic      raw_valid;
    logic      raw_ready;

    saih_hash u_hash (
        .clk       (clk),
        .rst_n     (rst_n),
        .id_valid  (id_valid),
        .id_byte   (id_byte),
        .id_last   (id_last),
        .id_stall  (id_stall),
        .raw       (raw),
        .raw_valid (raw_valid),
        .raw_ready (raw_ready)
    );

    saih_format u_format (
        .clk             (clk),
        .rst_n           (rst_n),
        .raw             (raw),
        .raw_valid       (raw_valid),
        .raw_ready       (raw_ready),
        .derived_address (derived_address),
        .derive_status   (derive_status),
        .addr_valid      (addr_valid),
        .addr_stall      (addr_stall)
    );

`ifndef SYNTHESIS
    a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        addr_valid && (derive_status != STATUS_OK) |-> derived_address == '0)
        else $error("nonzero address with failing status");

    a_type_bits: assert property (@(posedge clk) disable iff (!rst_n)
        addr_valid && (derive_status == STATUS_OK) |-> derived_address[ADDR_W-1 -: 2] == TYPE_BITS)
        else $error("type bits not set on good address");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        raw_valid && !raw_ready |-> id_stall)
        else $error("id transfer taken while middle stage blocked");

    a_mid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        raw_valid && !raw_ready |=> raw_valid && $stable(raw))
        else $error("middle stage lost a pending result");
`endif

endmodule
